@@ rtl/piecewise_linear_transfer_lut_defines.svh @@
// ----------------------------------------------------------------------------
// piecewise_linear_transfer_lut_defines.svh
// Assertion macros shared by the checker of the transfer lookup block.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_TRANSFER_LUT_DEFINES_SVH
`define PIECEWISE_LINEAR_TRANSFER_LUT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define PLT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define PLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/plt_pkg.sv @@
// ----------------------------------------------------------------------------
// plt_pkg
// Shared constants and controller/datapath command types.
// ----------------------------------------------------------------------------
`default_nettype none

package plt_pkg;

  localparam int unsigned POS_W      = 16;
  localparam int unsigned CHAN_W     = 16;
  localparam int unsigned NUM_CH     = 4;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned NIDX_W     = 4;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned QB         = 17;  // quotient bits before saturation
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 64;

  localparam int unsigned MAX_NODES_DEF  = 16;
  localparam int unsigned TABLE_SIZE_DEF = 256;

  localparam logic [15:0] FIX_ONE = 16'hFFFF;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic       node_wr;
    logic       idx_cap;
    logic       cap_n1;
    logic       cap_n0;
    logic       span;
    logic       prep;
    logic       ch_mul;
    logic       ch_prep;
    logic       div_step;
    logic       ch_fin;
    logic       out_hit;
    logic       out_zero;
    logic [1:0] ch;
  } plt_cmd_t;

  // status back to the sequencer
  typedef struct packed {
    logic seg_hit;
  } plt_stat_t;

endpackage

`default_nettype wire

@@ rtl/plt_dp.sv @@
// ----------------------------------------------------------------------------
// plt_dp
// Node stores, span check, slope multiply and shared restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module plt_dp #(
  parameter int unsigned MAX_NODES  = plt_pkg::MAX_NODES_DEF,
  parameter int unsigned TABLE_SIZE = plt_pkg::TABLE_SIZE_DEF
) (
  input  wire logic                              clk_i,
  input  wire plt_pkg::plt_cmd_t                 cmd_i,
  input  wire logic [$clog2(MAX_NODES)-1:0]      rd_addr_i,
  input  wire logic [plt_pkg::NIDX_W-1:0]        node_index_i,
  input  wire logic [plt_pkg::POS_W-1:0]         node_position_i,
  input  wire logic [plt_pkg::OUT_DATA_W-1:0]    node_color_i,
  input  wire logic [plt_pkg::IDX_W-1:0]         table_index_i,
  output plt_pkg::plt_stat_t                     stat_o,
  output logic [plt_pkg::OUT_DATA_W-1:0]         out_data_o,
  output logic                                   out_covered_o
);

  localparam int unsigned AW    = $clog2(MAX_NODES);
  localparam int unsigned TW    = $clog2(TABLE_SIZE);
  localparam logic [TW-1:0] T_VAL = TW'(TABLE_SIZE - 1);
  localparam int unsigned POS_W = plt_pkg::POS_W;
  localparam int unsigned CH_W  = plt_pkg::CHAN_W;
  localparam int unsigned QB    = plt_pkg::QB;
  localparam int unsigned SW    = POS_W + TW + 1;
  localparam int unsigned SPW   = SW - 15;
  localparam int unsigned AIW   = plt_pkg::IDX_W + POS_W;
  localparam int unsigned BW    = POS_W + TW;
  localparam int unsigned MW    = (AIW > BW) ? AIW : BW;
  localparam int unsigned DW    = POS_W + TW;
  localparam int unsigned NW    = CH_W + MW;
  localparam int unsigned CW    = ((NW + 2) > (DW + QB + 1)) ? (NW + 2) : (DW + QB + 1);
  localparam int unsigned KW    = (plt_pkg::IDX_W > SPW) ? plt_pkg::IDX_W : SPW;

  // rounded table position of a node: floor((x*T + 32767) / 65535)
  function automatic logic [SPW-1:0] span_of(input logic [POS_W-1:0] x);
    logic [SW-1:0] v;
    logic [SW-17:0] q0;
    logic [16:0] r;
    v  = SW'(x) * SW'(T_VAL) + SW'(16'h7FFF);
    q0 = v[SW-1:16];
    r  = 17'(v[15:0]) + 17'(q0);
    return SPW'(q0) + SPW'(r >= 17'(plt_pkg::FIX_ONE));
  endfunction

  logic [POS_W-1:0]               pos_mem [MAX_NODES];
  logic [plt_pkg::OUT_DATA_W-1:0] col_mem [MAX_NODES];
  logic [POS_W-1:0]               rd_pos_q;
  logic [plt_pkg::OUT_DATA_W-1:0] rd_col_q;

  logic [plt_pkg::IDX_W-1:0]      idx_q;
  logic [POS_W-1:0]               x0_q, x1_q;
  logic [plt_pkg::OUT_DATA_W-1:0] c0_q, c1_q;
  logic [SPW-1:0]                 start_q, stop_q;
  logic [MW-1:0]                  e_mag_q;
  logic                           e_neg_q, dx_neg_q;
  logic [DW-1:0]                  den_q;
  logic [NW-1:0]                  num_q;
  logic                           neg_q;
  logic [CH_W-1:0]                y0_q;
  logic [CW-1:0]                  rem_q, dcmp_q;
  logic [QB-1:0]                  quo_q;
  logic                           sat_q;
  logic [CH_W-1:0]                res_q [plt_pkg::NUM_CH];
  logic [plt_pkg::OUT_DATA_W-1:0] out_data_q;
  logic                           out_cov_q;

  // node store, one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.node_wr && (32'(node_index_i) < MAX_NODES)) begin
      pos_mem[AW'(node_index_i)] <= node_position_i;
      col_mem[AW'(node_index_i)] <= node_color_i;
    end
    rd_pos_q <= pos_mem[rd_addr_i];
    rd_col_q <= col_mem[rd_addr_i];
  end

  // span check against the latched index
  logic [KW-1:0] idx_k, start_k, stop_k;
  assign idx_k   = KW'(idx_q);
  assign start_k = KW'(start_q);
  assign stop_k  = KW'(stop_q);
  assign stat_o.seg_hit  = (x0_q != x1_q) &&
                           ((idx_k == start_k) || ((idx_k > start_k) && (idx_k <= stop_k)));

  // segment setup terms
  logic [MW-1:0]    a_w, b_w;
  logic [POS_W-1:0] dx_mag;
  assign a_w    = (MW'(idx_q) << 16) - MW'(idx_q);
  assign b_w    = MW'(x0_q) * MW'(T_VAL);
  assign dx_mag = (x1_q < x0_q) ? (x0_q - x1_q) : (x1_q - x0_q);

  // per-channel terms
  logic [CH_W-1:0] y0_w, y1_w, dy_mag;
  assign y0_w   = c0_q[cmd_i.ch*CH_W +: CH_W];
  assign y1_w   = c1_q[cmd_i.ch*CH_W +: CH_W];
  assign dy_mag = (y1_w < y0_w) ? (y0_w - y1_w) : (y1_w - y0_w);

  // rounded dividend, N = 2*num + den, divisor D = 2*den
  logic [CW-1:0] n_full, d_top;
  assign n_full = (CW'(num_q) << 1) + CW'(den_q);
  assign d_top  = CW'(den_q) << (QB + 1);

  // final add or subtract with clamp
  logic [QB-1:0] q_w;
  logic [QB:0]   sum_w;
  logic [CH_W-1:0] v_w;
  assign q_w   = sat_q ? {QB{1'b1}} : quo_q;
  assign sum_w = (QB + 1)'(y0_q) + (QB + 1)'(q_w);
  always_comb begin
    if (neg_q) begin
      v_w = ((QB)'(y0_q) < q_w) ? '0 : CH_W'((QB)'(y0_q) - q_w);
    end else begin
      v_w = (sum_w > (QB + 1)'(plt_pkg::FIX_ONE)) ? plt_pkg::FIX_ONE : CH_W'(sum_w);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.idx_cap) begin
      idx_q <= table_index_i;
    end
    if (cmd_i.cap_n1) begin
      x1_q <= rd_pos_q;
      c1_q <= rd_col_q;
    end
    if (cmd_i.cap_n0) begin
      x0_q <= rd_pos_q;
      c0_q <= rd_col_q;
    end
    if (cmd_i.span) begin
      start_q <= span_of(x0_q);
      stop_q  <= span_of(x1_q);
    end
    if (cmd_i.prep) begin
      e_neg_q  <= b_w > a_w;
      e_mag_q  <= (b_w > a_w) ? (b_w - a_w) : (a_w - b_w);
      dx_neg_q <= x1_q < x0_q;
      den_q    <= DW'(dx_mag) * DW'(T_VAL);
    end
    if (cmd_i.ch_mul) begin
      num_q <= NW'(dy_mag) * NW'(e_mag_q);
      neg_q <= (y1_w < y0_w) ^ e_neg_q ^ dx_neg_q;
      y0_q  <= y0_w;
    end
    if (cmd_i.ch_prep) begin
      sat_q  <= n_full >= d_top;
      rem_q  <= n_full;
      dcmp_q <= CW'(den_q) << QB;
      quo_q  <= '0;
    end
    if (cmd_i.div_step) begin
      if (rem_q >= dcmp_q) begin
        rem_q <= rem_q - dcmp_q;
        quo_q <= {quo_q[QB-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[QB-2:0], 1'b0};
      end
      dcmp_q <= dcmp_q >> 1;
    end
    if (cmd_i.ch_fin) begin
      res_q[cmd_i.ch] <= v_w;
    end
    if (cmd_i.out_hit) begin
      out_data_q <= {res_q[3], res_q[2], res_q[1], res_q[0]};
      out_cov_q  <= 1'b1;
    end else if (cmd_i.out_zero) begin
      out_data_q <= '0;
      out_cov_q  <= 1'b0;
    end
  end

  assign out_data_o    = out_data_q;
  assign out_covered_o = out_cov_q;

endmodule

`default_nettype wire

@@ rtl/plt_ctrl.sv @@
// ----------------------------------------------------------------------------
// plt_ctrl
// Sequencer: segment walk, channel loop, divider steps and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module plt_ctrl #(
  parameter int unsigned MAX_NODES = plt_pkg::MAX_NODES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_wr_en_i,
  input  wire logic [plt_pkg::CNT_W-1:0]     cfg_wr_data_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_func_i,
  output logic                               in_ready_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  input  wire plt_pkg::plt_stat_t            stat_i,
  output plt_pkg::plt_cmd_t                  cmd_o,
  output logic [$clog2(MAX_NODES)-1:0]       rd_addr_o
);

  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam logic [plt_pkg::STEP_W-1:0] LAST_STEP = plt_pkg::STEP_W'(plt_pkg::QB - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD1, ST_RD0, ST_CAP, ST_SPAN, ST_CHECK, ST_PREP,
    ST_MUL, ST_DPREP, ST_DIV, ST_FIN, ST_DONE_HIT, ST_DONE_ZERO
  } state_e;

  state_e                      state_q;
  logic [AW-1:0]               seg_q;
  logic [1:0]                  ch_q;
  logic [plt_pkg::STEP_W-1:0]  step_q;
  logic [plt_pkg::CNT_W-1:0]   node_count_q;
  logic                        out_valid_q;

  logic        accept, out_free, out_load;
  logic [31:0] n_eff;
  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = ((state_q == ST_DONE_HIT) || (state_q == ST_DONE_ZERO)) && out_free;
  assign n_eff    = (32'(node_count_q) > MAX_NODES) ? MAX_NODES : 32'(node_count_q);

  // sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      seg_q        <= '0;
      ch_q         <= '0;
      step_q       <= '0;
      node_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        node_count_q <= cfg_wr_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            seg_q <= AW'(n_eff - 32'd2);
            if (in_func_i && (n_eff >= 32'd2)) begin
              state_q <= ST_RD1;
            end else begin
              state_q <= ST_DONE_ZERO;
            end
          end
        end
        ST_RD1:   state_q <= ST_RD0;
        ST_RD0:   state_q <= ST_CAP;
        ST_CAP:   state_q <= ST_SPAN;
        ST_SPAN:  state_q <= ST_CHECK;
        ST_CHECK: begin
          if (stat_i.seg_hit) begin
            state_q <= ST_PREP;
          end else if (seg_q == '0) begin
            state_q <= ST_DONE_ZERO;
          end else begin
            seg_q   <= seg_q - 1'b1;
            state_q <= ST_RD1;
          end
        end
        ST_PREP: begin
          ch_q    <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: state_q <= ST_DPREP;
        ST_DPREP: begin
          step_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          step_q <= step_q + 1'b1;
          if (step_q == LAST_STEP) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (ch_q == 2'd3) begin
            state_q <= ST_DONE_HIT;
          end else begin
            ch_q    <= ch_q + 1'b1;
            state_q <= ST_MUL;
          end
        end
        ST_DONE_HIT, ST_DONE_ZERO: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // commands decoded from state
  always_comb begin
    cmd_o          = '0;
    cmd_o.ch       = ch_q;
    cmd_o.node_wr  = accept && !in_func_i;
    cmd_o.idx_cap  = accept && in_func_i;
    cmd_o.cap_n1   = (state_q == ST_RD0);
    cmd_o.cap_n0   = (state_q == ST_CAP);
    cmd_o.span     = (state_q == ST_SPAN);
    cmd_o.prep     = (state_q == ST_PREP);
    cmd_o.ch_mul   = (state_q == ST_MUL);
    cmd_o.ch_prep  = (state_q == ST_DPREP);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.ch_fin   = (state_q == ST_FIN);
    cmd_o.out_hit  = (state_q == ST_DONE_HIT) && out_free;
    cmd_o.out_zero = (state_q == ST_DONE_ZERO) && out_free;
  end

  assign rd_addr_o   = (state_q == ST_RD1) ? AW'(seg_q + 1'b1) : seg_q;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/piecewise_linear_transfer_lut.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_transfer_lut
// Piecewise-linear RGBA transfer function lookup over stored control nodes.
// ----------------------------------------------------------------------------
// One item at a time. A node write yields a zero, uncovered result.
// An evaluate walks the segments until one covers the index or none is
// left, and on a hit then computes all four channels: the node store has one
// read port, so each segment costs two reads plus span check, and each of
// the four channels then runs a 17-step restoring divide on one shared unit.
// A new item is accepted while a finished result still waits in the output
// register.
`default_nettype none

module piecewise_linear_transfer_lut #(
  parameter int unsigned MAX_NODES  = plt_pkg::MAX_NODES_DEF,
  parameter int unsigned TABLE_SIZE = plt_pkg::TABLE_SIZE_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_wr_en_i,
  input  wire logic [plt_pkg::CNT_W-1:0]          cfg_wr_data_i,   // node_count
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // node_index, node_position, node_red, node_green, node_blue, node_alpha,
  // table_index, zero pad
  input  wire logic [plt_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  input  wire logic                               s_axis_tuser_i,  // func
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // out_red, out_green, out_blue, out_alpha
  output logic [plt_pkg::OUT_DATA_W-1:0]          m_axis_tdata_o,
  output logic                                    m_axis_tuser_o   // covered
);

  plt_pkg::plt_cmd_t              cmd;
  plt_pkg::plt_stat_t             stat;
  logic [$clog2(MAX_NODES)-1:0]   rd_addr;

  // sequencer
  plt_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (s_axis_tvalid_i),
    .in_func_i     (s_axis_tuser_i),
    .in_ready_o    (s_axis_tready_o),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .stat_i        (stat),
    .cmd_o         (cmd),
    .rd_addr_o     (rd_addr)
  );

  // datapath
  plt_dp #(
    .MAX_NODES  (MAX_NODES),
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .rd_addr_i       (rd_addr),
    .node_index_i    (s_axis_tdata_i[3:0]),
    .node_position_i (s_axis_tdata_i[19:4]),
    .node_color_i    (s_axis_tdata_i[83:20]),
    .table_index_i   (s_axis_tdata_i[91:84]),
    .stat_o          (stat),
    .out_data_o      (m_axis_tdata_o),
    .out_covered_o   (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

@@ rtl/plt_checker.sv @@
// ----------------------------------------------------------------------------
// plt_checker
// Port-level checks of the transfer lookup block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "piecewise_linear_transfer_lut_defines.svh"

module plt_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid_i,
  input wire logic                            s_axis_tready_o,
  input wire logic                            m_axis_tvalid_o,
  input wire logic                            m_axis_tready_i,
  input wire logic [plt_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  input wire logic                            m_axis_tuser_o
);

  // a stalled result beat holds
  `PLT_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result changed while stalled")

  // an uncovered or write result carries zero channels
  `PLT_ASSERT_SAME(a_uncov_zero, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tdata_o == '0, "uncovered result not zero")

  // one item at a time: ready drops after an accepted beat
  `PLT_ASSERT_NEXT(a_one_item, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "second item taken while busy")

endmodule

bind piecewise_linear_transfer_lut plt_checker u_plt_checker (.*);

`default_nettype wire

@@ bench/piecewise_linear_transfer_lut_tb.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_transfer_lut_tb
// Self-checking bench for the piecewise-linear RGBA transfer lookup. Node
// writes and table evaluations are streamed in with random gaps and random
// output stalls, and every result beat is checked against a behavioral
// predictor of the segment search, interpolation and clamping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_transfer_lut_tb;

  localparam int NODES = 16;
  localparam longint TMAX = 255;
  localparam longint ONE = 65535;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef enum logic {FUNC_WRITE = 1'b0, FUNC_EVAL = 1'b1} func_e;

  typedef struct packed {
    func_e       func;
    logic [3:0]  nidx;
    logic [15:0] pos;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
    logic [7:0]  tidx;
  } lut_item_t;

  localparam int ITEM_W = $bits(lut_item_t);

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
    logic        covered;
  } rgba_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_wr_en_i = 1'b0;
  logic [plt_pkg::CNT_W-1:0] cfg_wr_data_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [plt_pkg::IN_DATA_W-1:0] s_axis_tdata_i = '0;
  logic s_axis_tuser_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [plt_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;

  piecewise_linear_transfer_lut dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0] node_pos [NODES];
  logic [15:0] node_col [NODES][4];
  logic [4:0]  node_cnt;

  lut_item_t pending_items[$];
  rgba_t     expected_rgba[$];
  int        errors = 0;
  longint    cycles = 0;
  bit        idle_free = 1'b0;
  int        hold_off = 0;
  bit        in_taken = 1'b0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic longint span_of(longint p);
    return (2 * p * TMAX + ONE) / (2 * ONE);
  endfunction

  function automatic longint lerp_clamp(longint y0, longint y1, longint x0, longint x1,
                                        longint idx);
    longint num, den, q, v;
    bit neg;
    num = (y1 - y0) * (idx * ONE - x0 * TMAX);
    den = (x1 - x0) * TMAX;
    neg = 1'b0;
    if (den < 0) begin den = -den; neg = !neg; end
    if (num < 0) begin num = -num; neg = !neg; end
    q = (2 * num + den) / (2 * den);
    v = y0 + (neg ? -q : q);
    if (v < 0) v = 0;
    if (v > ONE) v = ONE;
    return v;
  endfunction

  // apply one item to the predictor state and return the expected beat
  function automatic rgba_t predict_rgba(lut_item_t it);
    rgba_t r;
    longint n, x0, x1, s0, s1, idx;
    longint ch [4];
    r = '0;
    if (it.func == FUNC_WRITE) begin
      node_pos[it.nidx] = it.pos;
      node_col[it.nidx][0] = it.red;
      node_col[it.nidx][1] = it.green;
      node_col[it.nidx][2] = it.blue;
      node_col[it.nidx][3] = it.alpha;
      return r;
    end
    idx = it.tidx;
    n = (node_cnt > NODES) ? NODES : node_cnt;
    for (longint i = n - 2; i >= 0; i--) begin
      x0 = node_pos[i];
      x1 = node_pos[i + 1];
      if (x0 == x1) continue;
      s0 = span_of(x0);
      s1 = span_of(x1);
      if (!(idx == s0 || (idx > s0 && idx <= s1))) continue;
      for (int k = 0; k < 4; k++)
        ch[k] = lerp_clamp(node_col[i][k], node_col[i + 1][k], x0, x1, idx);
      r.red = 16'(ch[0]);
      r.green = 16'(ch[1]);
      r.blue = 16'(ch[2]);
      r.alpha = 16'(ch[3]);
      r.covered = 1'b1;
      break;
    end
    return r;
  endfunction

  function automatic lut_item_t node_item(int n, int p, bit rnd);
    lut_item_t it;
    it.func = FUNC_WRITE;
    it.nidx = 4'(n);
    it.pos = 16'(p);
    it.red = rnd ? 16'($urandom) : 16'hFFFF;
    it.green = rnd ? 16'($urandom) : 16'h0000;
    it.blue = rnd ? 16'($urandom) : 16'h8000;
    it.alpha = rnd ? 16'($urandom) : 16'h7FFF;
    it.tidx = 8'($urandom);
    return it;
  endfunction

  function automatic lut_item_t eval_item(int t);
    lut_item_t it;
    it = lut_item_t'(ITEM_W'({$urandom, $urandom, $urandom}));
    it.func = FUNC_EVAL;
    it.tidx = 8'(t);
    return it;
  endfunction

  // driver: offers pending items, changes inputs on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || in_taken) begin
        if (pending_items.size() > 0 && (idle_free || $urandom_range(99) >= 28)) begin
          lut_item_t it;
          it = pending_items.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i <= it.func;
          s_axis_tdata_i <= {4'h0, it.tidx, it.alpha, it.blue, it.green, it.red,
                             it.pos, it.nidx};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: ready changes on the falling edge, with a counted hold-off stretch
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= idle_free || $urandom_range(99) >= 28;
      end
    end
  end

  // input acceptance feeds the predictor
  always @(posedge clk_i) begin
    in_taken = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (in_taken) begin
      lut_item_t it;
      logic [plt_pkg::IN_DATA_W-1:0] d;
      d = s_axis_tdata_i;
      it.func = func_e'(s_axis_tuser_i);
      it.nidx = d[3:0];
      it.pos = d[19:4];
      it.red = d[35:20];
      it.green = d[51:36];
      it.blue = d[67:52];
      it.alpha = d[83:68];
      it.tidx = d[91:84];
      expected_rgba.push_back(predict_rgba(it));
    end
  end

  // monitor: checks result beats against the oldest expectation
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_rgba.size() == 0) begin
        report("unexpected beat", 0, 0);
      end else begin
        rgba_t e;
        e = expected_rgba.pop_front();
        if (m_axis_tdata_o[15:0] !== e.red) report("red", m_axis_tdata_o[15:0], e.red);
        if (m_axis_tdata_o[31:16] !== e.green)
          report("green", m_axis_tdata_o[31:16], e.green);
        if (m_axis_tdata_o[47:32] !== e.blue)
          report("blue", m_axis_tdata_o[47:32], e.blue);
        if (m_axis_tdata_o[63:48] !== e.alpha)
          report("alpha", m_axis_tdata_o[63:48], e.alpha);
        if (m_axis_tuser_o !== e.covered) report("covered", m_axis_tuser_o, e.covered);
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (pending_items.size() > 0 || s_axis_tvalid_i || expected_rgba.size() > 0)
      @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic set_count(int c);
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= plt_pkg::CNT_W'(c);
    node_cnt = 5'(c);
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
  endtask

  // write all nodes, with mostly rising random positions, duplicates sometimes
  task automatic load_nodes(int used);
    int p;
    p = $urandom_range(3000);
    for (int n = 0; n < NODES; n++) begin
      pending_items.push_back(node_item(n, p, 1'b1));
      if ($urandom_range(9) == 0) p = $urandom_range(65535);
      else if ($urandom_range(7) != 0) p = p + $urandom_range(65535 / (used + 1) * 2);
      if (p > 65535) p = 65535;
    end
  endtask

  initial begin
    int counts [6];
    counts = '{2, 16, 31, 5, 0, 1};
    for (int n = 0; n < NODES; n++) begin
      node_pos[n] = '0;
      for (int k = 0; k < 4; k++) node_col[n][k] = '0;
    end
    node_cnt = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, equal positions, decreasing segment
    set_count(4);
    pending_items.push_back(node_item(0, 0, 1'b0));
    pending_items.push_back(node_item(1, 65535, 1'b0));
    pending_items.push_back(node_item(2, 65535, 1'b1));
    pending_items.push_back(node_item(3, 128, 1'b1));
    pending_items.push_back(eval_item(0));
    pending_items.push_back(eval_item(255));
    pending_items.push_back(eval_item(127));
    pending_items.push_back(eval_item(128));
    pending_items.push_back(eval_item(1));
    pending_items.push_back(node_item(15, 65535, 1'b1));
    for (int n = 4; n < NODES; n++) pending_items.push_back(node_item(n, 65535, 1'b1));
    drain();

    // receiver holds off while the sender keeps offering
    for (int i = 0; i < 12; i++) pending_items.push_back(eval_item($urandom_range(255)));
    hold_off = 2000;
    drain();

    // random phases over several node counts
    for (int ph = 0; ph < 6; ph++) begin
      set_count(counts[ph]);
      load_nodes(counts[ph] > 16 ? 16 : (counts[ph] < 2 ? 2 : counts[ph]));
      idle_free = (ph == 2);
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(9) == 0) begin
          lut_item_t w;
          w = node_item($urandom_range(15), $urandom_range(65535), 1'b1);
          pending_items.push_back(w);
        end else begin
          pending_items.push_back(eval_item($urandom_range(255)));
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/plt_pkg.sv
rtl/plt_dp.sv
rtl/plt_ctrl.sv
rtl/piecewise_linear_transfer_lut.sv
rtl/plt_checker.sv
bench/piecewise_linear_transfer_lut_tb.sv
